FILE: sv/scpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package scpc_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int RANGE_BITS    = 16;

   localparam int ATAN_LEN  = 24;
   localparam int NUM_CELLS = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
   localparam int IDX_W     = $clog2(ATAN_LEN);

   // the input field is 16 bits, so the clipped range never needs more
   localparam int RANGE_W = (RANGE_BITS < 16) ? RANGE_BITS : 16;
   localparam logic [15:0] RANGE_MAX = 16'((32'd1 << RANGE_W) - 32'd1);

   // range with 16 fraction bits plus room for gain and overshoot
   localparam int VEC_W  = RANGE_W + 19;
   localparam int ANG_W  = 32;
   localparam int GAIN_W = 30;
   localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;

   localparam int OUT_W = 17;
   localparam logic signed [31:0] OUT_LIMIT = 32'sd65535;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_DECIMATION  = 2'd0,
      CSR_MIN_DIST    = 2'd1,
      CSR_START_ANGLE = 2'd2,
      CSR_ANGLE_STEP  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [ANG_W-1:0] z;
      logic                    point_valid;
      logic                    scan_end;
   } cell_data_type;

   // arctangent of 2^-i, 32 bits per full turn
   function automatic logic [ANG_W-1:0] atan_entry(input logic [IDX_W-1:0] idx);
      logic [ANG_W-1:0] val;
      case (idx)
         5'd0:    val = 32'd536870912;
         5'd1:    val = 32'd316933406;
         5'd2:    val = 32'd167458907;
         5'd3:    val = 32'd85004756;
         5'd4:    val = 32'd42667331;
         5'd5:    val = 32'd21354465;
         5'd6:    val = 32'd10679838;
         5'd7:    val = 32'd5340245;
         5'd8:    val = 32'd2670163;
         5'd9:    val = 32'd1335087;
         5'd10:   val = 32'd667544;
         5'd11:   val = 32'd333772;
         5'd12:   val = 32'd166886;
         5'd13:   val = 32'd83443;
         5'd14:   val = 32'd41722;
         5'd15:   val = 32'd20861;
         5'd16:   val = 32'd10430;
         5'd17:   val = 32'd5215;
         5'd18:   val = 32'd2608;
         5'd19:   val = 32'd1304;
         5'd20:   val = 32'd652;
         5'd21:   val = 32'd326;
         5'd22:   val = 32'd163;
         5'd23:   val = 32'd81;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

FILE: sv/scpc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module scpc_front (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_we,
   input  wire [scpc_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire [scpc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire                              in_valid,
   output logic                             in_ready,
   input  wire [15:0]                       in_range,
   input  wire                              in_last,
   output logic                             out_valid,
   input  wire                              out_ready,
   output scpc_pkg::cell_data_type          out_data
);
   import scpc_pkg::*;

   logic [7:0]  decimation_ff;
   logic [15:0] min_dist_ff;
   logic [15:0] start_angle_ff;
   logic [15:0] angle_step_ff;

   logic [15:0] angle_accum_ff, angle_accum_in;
   logic [7:0]  skip_count_ff, skip_count_in;
   logic        scan_begin_ff, scan_begin_in;

   // stage a: decimation and threshold decided, range clipped
   logic               a_valid_ff, a_valid_in;
   logic [RANGE_W-1:0] a_range_ff, a_range_in;
   logic [15:0]        a_angle_ff, a_angle_in;
   logic               a_point_ff, a_point_in;
   logic               a_end_ff, a_end_in;
   logic               a_ready;

   // stage b: gain applied, vector folded into the right half plane
   logic               b_valid_ff, b_valid_in;
   cell_data_type      b_data_ff, b_data_in;
   logic               b_ready;

   logic [7:0]  step_nz;
   logic [15:0] cur_angle;
   logic [7:0]  cur_cnt;
   logic [8:0]  cnt_next;
   logic        keep;
   logic        accept;

   logic [RANGE_W+GAIN_W-1:0] prod;
   logic signed [VEC_W-1:0]   x_start;
   logic [ANG_W-1:0]          z_start;

   assign b_ready   = !b_valid_ff || out_ready;
   assign a_ready   = !a_valid_ff || b_ready;
   assign in_ready  = a_ready;
   assign accept    = in_valid && in_ready;
   assign out_valid = b_valid_ff;
   assign out_data  = b_data_ff;

   always_comb begin
      step_nz   = (decimation_ff == 8'd0) ? 8'd1 : decimation_ff;
      cur_angle = scan_begin_ff ? start_angle_ff : angle_accum_ff;
      cur_cnt   = scan_begin_ff ? 8'd0 : skip_count_ff;
      cnt_next  = {1'b0, cur_cnt} + 9'd1;
      keep      = (cur_cnt == 8'd0) && (in_range > min_dist_ff);

      angle_accum_in = angle_accum_ff;
      skip_count_in  = skip_count_ff;
      scan_begin_in  = scan_begin_ff;
      if (accept) begin
         angle_accum_in = cur_angle + angle_step_ff;
         skip_count_in  = (cnt_next >= {1'b0, step_nz}) ? 8'd0 : cnt_next[7:0];
         scan_begin_in  = in_last;
      end

      a_valid_in = a_valid_ff;
      a_range_in = a_range_ff;
      a_angle_in = a_angle_ff;
      a_point_in = a_point_ff;
      a_end_in   = a_end_ff;
      if (a_ready) begin
         // samples that give neither a point nor a scan end are dropped here
         a_valid_in = accept && (keep || in_last);
         if (!keep) begin
            a_range_in = '0;
         end else if (in_range > RANGE_MAX) begin
            a_range_in = RANGE_MAX[RANGE_W-1:0];
         end else begin
            a_range_in = in_range[RANGE_W-1:0];
         end
         a_angle_in = cur_angle;
         a_point_in = keep;
         a_end_in   = in_last;
      end
   end

   always_comb begin
      prod    = {{GAIN_W{1'b0}}, a_range_ff} * {{RANGE_W{1'b0}}, GAIN_Q30};
      x_start = $signed({3'b000, prod[RANGE_W+GAIN_W-1:14]});
      z_start = {a_angle_ff, 16'h0000};
      // second and third quadrant: negate vector and turn by half a turn
      if (a_angle_ff[15] != a_angle_ff[14]) begin
         x_start = -x_start;
         z_start[ANG_W-1] = ~z_start[ANG_W-1];
      end

      b_valid_in = b_valid_ff;
      b_data_in  = b_data_ff;
      if (b_ready) begin
         b_valid_in            = a_valid_ff;
         b_data_in.x           = x_start;
         b_data_in.y           = '0;
         b_data_in.z           = $signed(z_start);
         b_data_in.point_valid = a_point_ff;
         b_data_in.scan_end    = a_end_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decimation_ff  <= 8'd3;
         min_dist_ff    <= 16'd250;
         start_angle_ff <= 16'd0;
         angle_step_ff  <= 16'd64;
         angle_accum_ff <= '0;
         skip_count_ff  <= '0;
         scan_begin_ff  <= 1'b1;
         a_valid_ff     <= 1'b0;
         b_valid_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               CSR_DECIMATION:  decimation_ff  <= csr_wdata[7:0];
               CSR_MIN_DIST:    min_dist_ff    <= csr_wdata;
               CSR_START_ANGLE: start_angle_ff <= csr_wdata;
               CSR_ANGLE_STEP:  angle_step_ff  <= csr_wdata;
               default: ;
            endcase
         end
         angle_accum_ff <= angle_accum_in;
         skip_count_ff  <= skip_count_in;
         scan_begin_ff  <= scan_begin_in;
         a_valid_ff     <= a_valid_in;
         b_valid_ff     <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_range_ff <= a_range_in;
      a_angle_ff <= a_angle_in;
      a_point_ff <= a_point_in;
      a_end_ff   <= a_end_in;
      b_data_ff  <= b_data_in;
   end

endmodule

`default_nettype wire

FILE: sv/scpc_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module scpc_cell (
   input  wire                            clock,
   input  wire                            reset,
   input  wire [scpc_pkg::IDX_W-1:0]      stage_idx,
   input  wire                            in_valid,
   output logic                           in_ready,
   input  scpc_pkg::cell_data_type        in_data,
   output logic                           out_valid,
   input  wire                            out_ready,
   output scpc_pkg::cell_data_type        out_data
);
   import scpc_pkg::*;

   logic          valid_ff, valid_in;
   cell_data_type data_ff, data_in;

   logic signed [VEC_W-1:0] x_sh;
   logic signed [VEC_W-1:0] y_sh;
   logic [ANG_W-1:0]        atan_val;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      x_sh     = in_data.x >>> stage_idx;
      y_sh     = in_data.y >>> stage_idx;
      atan_val = atan_entry(stage_idx);

      valid_in = valid_ff;
      data_in  = data_ff;
      if (in_ready) begin
         valid_in = in_valid;
         data_in  = in_data;
         // rotate toward zero residual angle
         if (!in_data.z[ANG_W-1]) begin
            data_in.x = in_data.x - y_sh;
            data_in.y = in_data.y + x_sh;
            data_in.z = in_data.z - $signed(atan_val);
         end else begin
            data_in.x = in_data.x + y_sh;
            data_in.y = in_data.y - x_sh;
            data_in.z = in_data.z + $signed(atan_val);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

`default_nettype wire

FILE: sv/scpc_out.sv
`timescale 1ns / 1ps
`default_nettype none

module scpc_out (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               in_valid,
   output logic                              in_ready,
   input  scpc_pkg::cell_data_type           in_data,
   output logic                              out_valid,
   input  wire                               out_ready,
   output logic signed [scpc_pkg::OUT_W-1:0] out_x,
   output logic signed [scpc_pkg::OUT_W-1:0] out_y,
   output logic                              out_point,
   output logic                              out_end
);
   import scpc_pkg::*;

   logic                    valid_ff, valid_in;
   logic signed [OUT_W-1:0] x_ff, x_in;
   logic signed [OUT_W-1:0] y_ff, y_in;
   logic                    point_ff, point_in;
   logic                    end_ff, end_in;

   logic signed [VEC_W:0] x_rnd, y_rnd;
   logic signed [31:0]    x_int, y_int;
   logic signed [31:0]    x_sat, y_sat;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_point = point_ff;
   assign out_end   = end_ff;

   always_comb begin
      // round half up, then drop the 16 fraction bits
      x_rnd = {in_data.x[VEC_W-1], in_data.x} + (VEC_W+1)'(32768);
      y_rnd = {in_data.y[VEC_W-1], in_data.y} + (VEC_W+1)'(32768);
      x_int = {{(32-(VEC_W-15)){x_rnd[VEC_W]}}, x_rnd[VEC_W:16]};
      y_int = {{(32-(VEC_W-15)){y_rnd[VEC_W]}}, y_rnd[VEC_W:16]};

      x_sat = x_int;
      if (x_int > OUT_LIMIT) x_sat = OUT_LIMIT;
      if (x_int < -OUT_LIMIT) x_sat = -OUT_LIMIT;
      y_sat = y_int;
      if (y_int > OUT_LIMIT) y_sat = OUT_LIMIT;
      if (y_int < -OUT_LIMIT) y_sat = -OUT_LIMIT;

      valid_in = valid_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      point_in = point_ff;
      end_in   = end_ff;
      if (in_ready) begin
         valid_in = in_valid;
         x_in     = in_data.point_valid ? x_sat[OUT_W-1:0] : '0;
         y_in     = in_data.point_valid ? y_sat[OUT_W-1:0] : '0;
         point_in = in_data.point_valid;
         end_in   = in_data.scan_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      point_ff <= point_in;
      end_ff   <= end_in;
   end

endmodule

`default_nettype wire

FILE: sv/scan_points_polar_to_cartesian_core.sv
// Turns a lidar range scan into Cartesian points. Each req beat carries one
// range sample in millimetres, tlast on the final sample of a scan. One sample
// in decimation_step (counted from scan start) is kept, and only if its range
// is strictly above min_distance_mm; its angle is start_angle plus the sample
// index times angle_step, in 16-bit binary angle (32768 = pi). Each survivor
// leaves as one rsp beat with x and y rounded and saturated to +-65535 and
// tuser high; the last sample of a scan always gives a beat with tlast high,
// carrying zeros and tuser low when it yields no point. Dropped samples give
// no beat. The block takes one sample per clock unless rsp_tready holds it
// back: every stage is a pipeline register with its own valid, so it passes
// one beat per cycle while the output is not stalled. The stages, in order,
// are decimation and thresholding, the gain multiply and quadrant fold, one
// per rotation cell, and rounding into the output register. The user must
// write registers through csr_we/csr_addr/csr_wdata only while the pipe is
// empty; the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module scan_points_polar_to_cartesian_core (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_we,
   input  wire [scpc_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire [scpc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire [15:0]                       req_tdata,   // range_mm
   input  wire                              req_tlast,   // scan_last
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [39:0]                      rsp_tdata,   // pos_x_mm, pos_y_mm, zero pad
   output logic                             rsp_tuser,   // point_valid
   output logic                             rsp_tlast    // scan_end
);
   import scpc_pkg::*;

   logic          chain_valid [0:NUM_CELLS];
   logic          chain_ready [0:NUM_CELLS];
   cell_data_type chain_data  [0:NUM_CELLS];

   logic signed [OUT_W-1:0] pos_x;
   logic signed [OUT_W-1:0] pos_y;

   scpc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_range  (req_tdata),
      .in_last   (req_tlast),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_data  (chain_data[0])
   );

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      scpc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_idx (IDX_W'(i)),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   scpc_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid[NUM_CELLS]),
      .in_ready  (chain_ready[NUM_CELLS]),
      .in_data   (chain_data[NUM_CELLS]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_x     (pos_x),
      .out_y     (pos_y),
      .out_point (rsp_tuser),
      .out_end   (rsp_tlast)
   );

   assign rsp_tdata = {6'b000000, pos_y, pos_x};

`ifndef NO_ASSERTIONS
   // a beat without a point exists only to mark the scan end
   a_end_only: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast)
      else $error("result beat with neither point nor scan end");

   // end marker beats carry zero coordinates
   a_end_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[33:0] == 34'd0)
      else $error("end marker beat with nonzero coordinates");

   // saturation keeps both coordinates off the most negative code
   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[16:0] != 17'h10000 && rsp_tdata[33:17] != 17'h10000)
      else $error("coordinate outside saturation limits");
`endif

endmodule

`default_nettype wire
